@@ sv/edge_pair_angle_core_assert.svh @@
// assertion macros for the edge pair angle design
`ifndef EDGE_PAIR_ANGLE_CORE_ASSERT_SVH
`define EDGE_PAIR_ANGLE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EPA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define EPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/epa_pkg.sv @@
`timescale 1ns / 1ps
package epa_pkg;

   // scaled direction components fit 15 bits signed
   localparam int VEC_W = 15;
   localparam int COMP_BITS = 14;

   // angle accumulator, degrees scaled by 2^24
   localparam int TABLE_FRAC = 24;
   localparam int Z_W = 35;
   localparam int X_W = 34;
   localparam int MAX_STEPS = 32;

   localparam int OUT_W = 16;
   localparam int OUT_MAX = 65535;

   localparam int QUEUE_DEPTH = 4;

   localparam logic signed [Z_W-1:0] DEG90 = Z_W'(longint'(90) << TABLE_FRAC);
   localparam logic signed [Z_W-1:0] DEG180 = Z_W'(longint'(180) << TABLE_FRAC);

   // one classified edge pair between front and back
   typedef struct packed {
      logic signed [VEC_W-1:0] ax;
      logic signed [VEC_W-1:0] ay;
      logic signed [VEC_W-1:0] az;
      logic signed [VEC_W-1:0] bx;
      logic signed [VEC_W-1:0] by;
      logic signed [VEC_W-1:0] bz;
      logic                    degen;
   } dir_item_type;

   // arctangent of 2^-idx in degrees, scaled by 2^24
   function automatic logic [31:0] atan_q24(input int unsigned idx);
      logic [31:0] v;
      unique case (idx)
         0: v = 32'd754974720;
         1: v = 32'd445687602;
         2: v = 32'd235489088;
         3: v = 32'd119537938;
         4: v = 32'd60000934;
         5: v = 32'd30029717;
         6: v = 32'd15018523;
         7: v = 32'd7509720;
         8: v = 32'd3754917;
         9: v = 32'd1877466;
         10: v = 32'd938734;
         11: v = 32'd469367;
         12: v = 32'd234684;
         13: v = 32'd117342;
         14: v = 32'd58671;
         15: v = 32'd29335;
         16: v = 32'd14668;
         17: v = 32'd7334;
         18: v = 32'd3667;
         19: v = 32'd1833;
         20: v = 32'd917;
         21: v = 32'd458;
         22: v = 32'd229;
         23: v = 32'd115;
         24: v = 32'd57;
         25: v = 32'd29;
         26: v = 32'd14;
         27: v = 32'd7;
         28: v = 32'd4;
         29: v = 32'd2;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/epa_front.sv @@
`timescale 1ns / 1ps
module epa_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_start [2][3],
   input  logic signed [COORD_WIDTH-1:0] in_stop [2][3],
   output logic                          out_valid,
   input  logic                          out_ready,
   output epa_pkg::dir_item_type         out_item
);
   import epa_pkg::*;

   localparam int SQ_W = 2 * COORD_WIDTH;
   localparam int DIF_W = COORD_WIDTH + 1;
   localparam int EXT_W = (DIF_W > VEC_W) ? DIF_W : VEC_W;
   localparam int KW = $clog2(DIF_W + 1);

   logic [4:0] vld_ff, vld_in;
   logic       adv;

   logic signed [COORD_WIDTH-1:0] st_ff [2][3], st_in [2][3];
   logic signed [COORD_WIDTH-1:0] sp_ff [2][3], sp_in [2][3];
   logic signed [COORD_WIDTH-1:0] st2_ff [2][3], sp2_ff [2][3];
   logic signed [SQ_W-1:0]        sqs_ff [2][3], sqs_in [2][3];
   logic signed [SQ_W-1:0]        sqp_ff [2][3], sqp_in [2][3];
   logic        [SQ_W-1:0]        len_s [2], len_p [2];
   logic signed [DIF_W-1:0]       dif_ff [2][3], dif_in [2][3];
   logic signed [DIF_W-1:0]       dif4_ff [2][3];
   logic        [DIF_W-1:0]       mag [2][3];
   logic        [DIF_W-1:0]       m_ff [2], m_in [2];
   logic        [KW-1:0]          hi [2], k [2];
   logic signed [EXT_W-1:0]       shv [2][3];
   dir_item_type                  item_ff, item_in;

   assign adv = !vld_ff[4] || out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[4];
   assign out_item = item_ff;
   assign vld_in = {vld_ff[3:0], in_valid};

   // squares, direction choice, largest component, scaling
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int c = 0; c < 3; c++) begin
            st_in[e][c] = in_start[e][c];
            sp_in[e][c] = in_stop[e][c];
            sqs_in[e][c] = st_ff[e][c] * st_ff[e][c];
            sqp_in[e][c] = sp_ff[e][c] * sp_ff[e][c];
         end
         len_s[e] = $unsigned(sqs_ff[e][0]) + $unsigned(sqs_ff[e][1])
                  + $unsigned(sqs_ff[e][2]);
         len_p[e] = $unsigned(sqp_ff[e][0]) + $unsigned(sqp_ff[e][1])
                  + $unsigned(sqp_ff[e][2]);
         for (int c = 0; c < 3; c++) begin
            if (len_s[e] > len_p[e]) begin
               dif_in[e][c] = DIF_W'(st2_ff[e][c]) - DIF_W'(sp2_ff[e][c]);
            end else begin
               dif_in[e][c] = DIF_W'(sp2_ff[e][c]) - DIF_W'(st2_ff[e][c]);
            end
            mag[e][c] = dif_ff[e][c][DIF_W-1] ? $unsigned(-dif_ff[e][c])
                                              : $unsigned(dif_ff[e][c]);
         end
         m_in[e] = mag[e][0];
         if (mag[e][1] > m_in[e]) m_in[e] = mag[e][1];
         if (mag[e][2] > m_in[e]) m_in[e] = mag[e][2];
         // bit length of the largest magnitude gives the right shift
         hi[e] = '0;
         for (int j = 0; j < DIF_W; j++) begin
            if (m_ff[e][j]) hi[e] = KW'(j + 1);
         end
         k[e] = (hi[e] > KW'(COMP_BITS)) ? hi[e] - KW'(COMP_BITS) : '0;
         for (int c = 0; c < 3; c++) begin
            shv[e][c] = EXT_W'(dif4_ff[e][c]) >>> k[e];
         end
      end
      item_in.ax = shv[0][0][VEC_W-1:0];
      item_in.ay = shv[0][1][VEC_W-1:0];
      item_in.az = shv[0][2][VEC_W-1:0];
      item_in.bx = shv[1][0][VEC_W-1:0];
      item_in.by = shv[1][1][VEC_W-1:0];
      item_in.bz = shv[1][2][VEC_W-1:0];
      item_in.degen = (m_ff[0] == '0) || (m_ff[1] == '0);
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
         sp_ff <= sp_in;
         st2_ff <= st_ff;
         sp2_ff <= sp_ff;
         sqs_ff <= sqs_in;
         sqp_ff <= sqp_in;
         dif_ff <= dif_in;
         dif4_ff <= dif_ff;
         m_ff <= m_in;
         item_ff <= item_in;
      end
   end

endmodule

@@ sv/epa_fifo.sv @@
`timescale 1ns / 1ps
module epa_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   input  epa_pkg::dir_item_type wr_item,
   output logic                  full,
   output logic                  rd_valid,
   output epa_pkg::dir_item_type rd_item,
   input  logic                  rd_pop
);
   import epa_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dir_item_type  slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          wr, rd;

   assign full = (cnt_ff == CW'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_item = slot_ff[rp_ff];
   assign wr = wr_valid && !full;
   assign rd = rd_pop && rd_valid;

   // pointer and fill count update
   always_comb begin
      wp_in = wr ? wp_ff + PW'(1) : wp_ff;
      rp_in = rd ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + CW'(wr) - CW'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wp_ff] <= wr_item;
      end
   end

endmodule

@@ sv/epa_back.sv @@
`timescale 1ns / 1ps
module epa_back #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  epa_pkg::dir_item_type        in_item,
   output logic                         in_pop,
   output logic                         out_valid,
   input  logic                         out_pop,
   output logic [epa_pkg::OUT_W-1:0]    out_angle,
   output logic                         out_degenerate
);
   import epa_pkg::*;

   localparam int PRD_W = 2 * VEC_W;
   localparam int CRS_W = PRD_W + 1;
   localparam int DOT_W = PRD_W + 2;
   localparam int C2_W = 2 * CRS_W;
   localparam int ROOT_W = CRS_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int NV = 5 + ROOT_W + STEPS;
   localparam int SH = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam logic [Z_W-1:0] HALF = Z_W'(1) << (SH - 1);

   logic          adv;
   logic [NV-1:0] vld_ff, vld_in;
   logic          ovld_ff;

   dir_item_type             it_ff;
   logic signed [PRD_W-1:0]  prd_ff [9], prd_in [9];
   logic                     dg1_ff, dg2_ff, dg3_ff;
   logic signed [CRS_W-1:0]  crs_ff [3], crs_in [3];
   logic        [CRS_W-1:0]  cmag [3];
   logic signed [DOT_W-1:0]  dot2_ff, dot2_in, dot3_ff;
   logic        [C2_W-1:0]   csq_ff [3], csq_in [3];
   logic        [C2_W-1:0]   c2_in;

   // square root pipeline, entry 0 loads from the cross stage
   logic        [C2_W-1:0]   sq_n_ff [ROOT_W+1];
   logic        [REM_W-1:0]  sq_rem_ff [ROOT_W+1];
   logic        [ROOT_W-1:0] sq_root_ff [ROOT_W+1];
   logic signed [DOT_W-1:0]  sq_dot_ff [ROOT_W+1];
   logic                     sq_dg_ff [ROOT_W+1];

   // rotation pipeline
   logic signed [X_W-1:0]    cd_x_ff [STEPS];
   logic signed [X_W-1:0]    cd_y_ff [STEPS];
   logic signed [Z_W-1:0]    cd_z_ff [STEPS];
   logic                     cd_dg_ff [STEPS];

   logic signed [Z_W-1:0]    tsum, tcl;
   logic        [Z_W-1:0]    rnd;
   logic        [OUT_W-1:0]  ang_ff, ang_in;
   logic                     odg_ff;

   assign adv = !ovld_ff || out_pop;
   assign in_pop = adv && in_valid;
   assign out_valid = ovld_ff;
   assign out_angle = ang_ff;
   assign out_degenerate = odg_ff;
   assign vld_in = {vld_ff[NV-2:0], in_valid};

   // products, cross and dot sums, squared cross length
   always_comb begin
      prd_in[0] = it_ff.ay * it_ff.bz;
      prd_in[1] = it_ff.az * it_ff.by;
      prd_in[2] = it_ff.az * it_ff.bx;
      prd_in[3] = it_ff.ax * it_ff.bz;
      prd_in[4] = it_ff.ax * it_ff.by;
      prd_in[5] = it_ff.ay * it_ff.bx;
      prd_in[6] = it_ff.ax * it_ff.bx;
      prd_in[7] = it_ff.ay * it_ff.by;
      prd_in[8] = it_ff.az * it_ff.bz;
      for (int c = 0; c < 3; c++) begin
         crs_in[c] = CRS_W'(prd_ff[2*c]) - CRS_W'(prd_ff[2*c+1]);
         cmag[c] = crs_ff[c][CRS_W-1] ? $unsigned(-crs_ff[c]) : $unsigned(crs_ff[c]);
         csq_in[c] = C2_W'(cmag[c]) * C2_W'(cmag[c]);
      end
      dot2_in = DOT_W'(prd_ff[6]) + DOT_W'(prd_ff[7]) + DOT_W'(prd_ff[8]);
      c2_in = csq_ff[0] + csq_ff[1] + csq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ovld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
         ovld_ff <= vld_ff[NV-1];
      end
   end

   // front stages of the back end
   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff <= in_item;
         prd_ff <= prd_in;
         dg1_ff <= it_ff.degen;
         crs_ff <= crs_in;
         dot2_ff <= dot2_in;
         dg2_ff <= dg1_ff;
         csq_ff <= csq_in;
         dot3_ff <= dot2_ff;
         dg3_ff <= dg2_ff;
         sq_n_ff[0] <= c2_in;
         sq_rem_ff[0] <= '0;
         sq_root_ff[0] <= '0;
         sq_dot_ff[0] <= dot3_ff;
         sq_dg_ff[0] <= dg3_ff;
      end
   end

   // one root bit per stage
   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  test;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         trial = {sq_rem_ff[j], sq_n_ff[j][C2_W-1 -: 2]};
         test = (REM_W+2)'({sq_root_ff[j], 2'b01});
         if (trial >= test) begin
            rem_in = REM_W'(trial - test);
            root_in = {sq_root_ff[j][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = REM_W'(trial);
            root_in = {sq_root_ff[j][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_n_ff[j+1] <= sq_n_ff[j] << 2;
            sq_rem_ff[j+1] <= rem_in;
            sq_root_ff[j+1] <= root_in;
            sq_dot_ff[j+1] <= sq_dot_ff[j];
            sq_dg_ff[j+1] <= sq_dg_ff[j];
         end
      end
   end

   // vectoring rotation toward the x axis, one step per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      logic signed [X_W-1:0] x_cur, y_cur, x_in, y_in;
      logic signed [Z_W-1:0] z_cur, z_in;
      logic                  dg_cur;

      if (i == 0) begin : g_first
         assign x_cur = X_W'(sq_root_ff[ROOT_W]);
         assign y_cur = -X_W'(sq_dot_ff[ROOT_W]);
         assign z_cur = '0;
         assign dg_cur = sq_dg_ff[ROOT_W];
      end else begin : g_next
         assign x_cur = cd_x_ff[i-1];
         assign y_cur = cd_y_ff[i-1];
         assign z_cur = cd_z_ff[i-1];
         assign dg_cur = cd_dg_ff[i-1];
      end

      always_comb begin
         if (y_cur > 0) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + Z_W'(atan_q24(i));
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - Z_W'(atan_q24(i));
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cd_x_ff[i] <= x_in;
            cd_y_ff[i] <= y_in;
            cd_z_ff[i] <= z_in;
            cd_dg_ff[i] <= dg_cur;
         end
      end
   end

   // offset by 90 degrees, clamp, round half up, saturate
   always_comb begin
      tsum = cd_dg_ff[STEPS-1] ? DEG90 : DEG90 + cd_z_ff[STEPS-1];
      if (tsum < 0) begin
         tcl = '0;
      end else if (tsum > DEG180) begin
         tcl = DEG180;
      end else begin
         tcl = tsum;
      end
      rnd = ($unsigned(tcl) + HALF) >> SH;
      ang_in = (rnd > Z_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : rnd[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff <= ang_in;
         odg_ff <= cd_dg_ff[STEPS-1];
      end
   end

endmodule

@@ sv/edge_pair_angle_core.sv @@
// throughput: one item per cycle while rsp_pop keeps up; set by the fully pipelined
//   square root (31 stages) and rotation unit (CORDIC_STEPS stages, at most 32)
// a four-entry queue splits the direction front end from the angle back end
// reset: synchronous, active high; clears all valid bits and queue pointers, no results held
`timescale 1ns / 1ps
`include "edge_pair_angle_core_assert.svh"
module edge_pair_angle_core #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_first_stop_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_stop_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_stop_z,
   input  logic signed [COORD_WIDTH-1:0] req_other_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_other_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_other_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_other_stop_x,
   input  logic signed [COORD_WIDTH-1:0] req_other_stop_y,
   input  logic signed [COORD_WIDTH-1:0] req_other_stop_z,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [epa_pkg::OUT_W-1:0]     rsp_angle_degrees,
   output logic                          rsp_degenerate
);
   import epa_pkg::*;

   localparam int SH = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam longint A90_RAW = ((longint'(90) << TABLE_FRAC) + (longint'(1) << (SH - 1))) >> SH;
   localparam longint A180_RAW = ((longint'(180) << TABLE_FRAC) + (longint'(1) << (SH - 1))) >> SH;
   localparam longint ANGLE_90 = (A90_RAW > OUT_MAX) ? OUT_MAX : A90_RAW;
   localparam longint ANGLE_180 = (A180_RAW > OUT_MAX) ? OUT_MAX : A180_RAW;

   logic signed [COORD_WIDTH-1:0] start_c [2][3];
   logic signed [COORD_WIDTH-1:0] stop_c [2][3];
   logic                          front_ready, f_valid, q_full, q_valid, q_pop;
   logic                          b_valid;
   dir_item_type                  f_item, q_item;

   // gather endpoints by edge
   assign start_c[0][0] = req_first_start_x;
   assign start_c[0][1] = req_first_start_y;
   assign start_c[0][2] = req_first_start_z;
   assign stop_c[0][0] = req_first_stop_x;
   assign stop_c[0][1] = req_first_stop_y;
   assign stop_c[0][2] = req_first_stop_z;
   assign start_c[1][0] = req_other_start_x;
   assign start_c[1][1] = req_other_start_y;
   assign start_c[1][2] = req_other_start_z;
   assign stop_c[1][0] = req_other_stop_x;
   assign stop_c[1][1] = req_other_stop_y;
   assign stop_c[1][2] = req_other_stop_z;

   assign req_full = !front_ready;
   assign rsp_empty = !b_valid;

   epa_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push),
      .in_ready (front_ready),
      .in_start (start_c),
      .in_stop  (stop_c),
      .out_valid(f_valid),
      .out_ready(!q_full),
      .out_item (f_item)
   );

   epa_fifo u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(f_valid),
      .wr_item (f_item),
      .full    (q_full),
      .rd_valid(q_valid),
      .rd_item (q_item),
      .rd_pop  (q_pop)
   );

   epa_back #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .CORDIC_STEPS   (CORDIC_STEPS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_item       (q_item),
      .in_pop        (q_pop),
      .out_valid     (b_valid),
      .out_pop       (rsp_pop),
      .out_angle     (rsp_angle_degrees),
      .out_degenerate(rsp_degenerate)
   );

   // checks
   `EPA_ASSERT_IMPLY(a_degen_right_angle, clock, reset, !rsp_empty && rsp_degenerate, rsp_angle_degrees == OUT_W'(ANGLE_90), "degenerate result is not 90 degrees")
   `EPA_ASSERT_IMPLY(a_angle_range, clock, reset, !rsp_empty, rsp_angle_degrees <= OUT_W'(ANGLE_180), "angle above 180 degrees")
   `EPA_ASSERT_NEXT(a_queue_full_holds, clock, reset, q_full && !q_pop, q_full, "queue lost an entry without a transfer")

endmodule

@@ bench/edge_pair_angle_checker.sv @@
`timescale 1ns / 1ps
module edge_pair_angle_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic [11:0][15:0] req_coords,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [15:0]       rsp_angle_degrees,
   input  logic              rsp_degenerate,
   output int                fail_count,
   output int                pending_count
);

   typedef struct {
      logic [15:0] angle;
      logic        degen;
   } angle_result_t;

   // arctangent of 2^-i in degrees, scaled by 2^24
   localparam longint ATAN_DEG[16] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
      58671, 29335};
   localparam int ROT_STEPS = 16;
   localparam int OUT_SHIFT = 24 - 8;

   angle_result_t expected_angles[$];
   int            accepted;

   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // direction from nearer to farther endpoint, scaled to 14 magnitude bits
   function automatic logic edge_direction(input logic [5:0][15:0] pts,
                                           output longint d[3]);
      longint s[3];
      longint e[3];
      longint unsigned ls, le, m;
      int k;
      m = 0;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         s[i] = longint'($signed(pts[i]));
         e[i] = longint'($signed(pts[3 + i]));
      end
      ls = mag(s[0]) * mag(s[0]) + mag(s[1]) * mag(s[1]) + mag(s[2]) * mag(s[2]);
      le = mag(e[0]) * mag(e[0]) + mag(e[1]) * mag(e[1]) + mag(e[2]) * mag(e[2]);
      for (int i = 0; i < 3; i++) begin
         d[i] = (ls > le) ? s[i] - e[i] : e[i] - s[i];
         if (mag(d[i]) > m) m = mag(d[i]);
      end
      while ((m >> k) > 16383) k++;
      for (int i = 0; i < 3; i++) d[i] = d[i] >>> k;
      return m == 0;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] round_angle(input longint q24);
      longint v;
      v = (q24 + (longint'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      return (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic angle_result_t predict_angle(input logic [11:0][15:0] c);
      longint a[3];
      longint b[3];
      longint cx, cy, cz, x, y, z, t;
      logic za, zb;
      angle_result_t r;
      za = edge_direction(c[5:0], a);
      zb = edge_direction(c[11:6], b);
      if (za || zb) begin
         r.angle = round_angle(longint'(90) << 24);
         r.degen = 1'b1;
         return r;
      end
      cx = a[1] * b[2] - a[2] * b[1];
      cy = a[2] * b[0] - a[0] * b[2];
      cz = a[0] * b[1] - a[1] * b[0];
      x = longint'(floor_sqrt(mag(cx) * mag(cx) + mag(cy) * mag(cy) + mag(cz) * mag(cz)));
      y = -(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      z = 0;
      // vectoring rotation toward the x axis
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (y > 0) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_DEG[i];
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_DEG[i];
         end
         x = t;
      end
      t = (longint'(90) << 24) + z;
      if (t < 0) t = 0;
      if (t > (longint'(180) << 24)) t = longint'(180) << 24;
      r.angle = round_angle(t);
      r.degen = 1'b0;
      return r;
   endfunction

   assign pending_count = expected_angles.size();

   // predict on input transfer, compare on result transfer
   always @(posedge clock) begin
      angle_result_t want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_push && !req_full) expected_angles.push_back(predict_angle(req_coords));
         if (rsp_pop && !rsp_empty) begin
            if (expected_angles.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result angle=%0d degen=%0b",
                           rsp_angle_degrees, rsp_degenerate);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_angles.pop_front();
               if (want.angle !== rsp_angle_degrees || want.degen !== rsp_degenerate) begin
                  if (fail_count < 10)
                     $display("result %0d: expected angle=%0d degen=%0b, got angle=%0d degen=%0b",
                              accepted, want.angle, want.degen,
                              rsp_angle_degrees, rsp_degenerate);
                  fail_count <= fail_count + 1;
               end
            end
            accepted++;
         end
      end
   end

   initial accepted = 0;

endmodule

@@ bench/tb_edge_pair_angle_core.sv @@
`timescale 1ns / 1ps
module tb_edge_pair_angle_core;

   typedef logic [11:0][15:0] coord_set_type;

   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_LIMIT = 3000;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   coord_set_type req_coords;
   logic rsp_empty;
   logic rsp_pop;
   logic [15:0] rsp_angle_degrees;
   logic rsp_degenerate;
   int fail_count;
   int pending_count;
   int stall_left;
   int hold_left;
   int popped;
   int idle_cycles;

   edge_pair_angle_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_first_start_x(req_coords[0]),
      .req_first_start_y(req_coords[1]),
      .req_first_start_z(req_coords[2]),
      .req_first_stop_x(req_coords[3]),
      .req_first_stop_y(req_coords[4]),
      .req_first_stop_z(req_coords[5]),
      .req_other_start_x(req_coords[6]),
      .req_other_start_y(req_coords[7]),
      .req_other_start_z(req_coords[8]),
      .req_other_stop_x(req_coords[9]),
      .req_other_stop_y(req_coords[10]),
      .req_other_stop_z(req_coords[11]),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_angle_degrees(rsp_angle_degrees),
      .rsp_degenerate(rsp_degenerate)
   );

   edge_pair_angle_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_coords(req_coords),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_angle_degrees(rsp_angle_degrees),
      .rsp_degenerate(rsp_degenerate),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random stalls, one long hold-off, one stretch without stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         popped = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            popped++;
            stall_left = (popped > 400 && popped < 500) ? 0 : $urandom_range(0, 3);
            if (popped == 150) hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one item after a random gap and hold it until the transfer
   task automatic offer(input coord_set_type c);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_coords <= c;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] small_coord();
      return 16'($signed($urandom_range(0, 1024)) - 512);
   endfunction

   function automatic coord_set_type random_pair();
      coord_set_type c;
      int kind;
      logic [15:0] dx, dy, dz;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) c[i] = (kind < 3) ? 16'($urandom) : small_coord();
      if (kind == 6) begin
         // other edge nearly parallel to the first edge
         dx = c[3] - c[0];
         dy = c[4] - c[1];
         dz = c[5] - c[2];
         c[9] = c[6] + dx + 16'($urandom_range(0, 2));
         c[10] = c[7] + dy;
         c[11] = c[8] + dz - 16'($urandom_range(0, 2));
      end else if (kind == 7) begin
         // endpoints of the first edge equally far from the origin
         c[3] = -c[0];
         c[4] = -c[1];
         c[5] = -c[2];
      end else if (kind == 8) begin
         // collapsed edge on a random side
         if ($urandom_range(0, 1)) c[11:9] = c[8:6];
         else c[5:3] = c[2:0];
      end
      return c;
   endfunction

   initial begin
      coord_set_type d[$];
      coord_set_type c;
      reset = 1'b1;
      req_push = 1'b0;
      req_coords = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: degenerate edges, extremes, equal distances, simple angles
      c = '0;
      d.push_back(c);
      c = '0; c[3] = 16'h0100;
      d.push_back(c);
      c = '0; c[9] = 16'h0100;
      d.push_back(c);
      c = '0; c[3] = 16'h0100; c[9] = 16'h0100;
      d.push_back(c);
      c = '0; c[3] = 16'h0100; c[9] = 16'hFF00;
      d.push_back(c);
      c = '0; c[3] = 16'h0100; c[10] = 16'h0100;
      d.push_back(c);
      c = '0; c[3] = 16'h0100; c[4] = 16'h0100; c[9] = 16'h0100;
      d.push_back(c);
      for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 16'h7FFF : 16'h8000;
      d.push_back(c);
      for (int i = 0; i < 12; i++) c[i] = (i < 3 || (i >= 6 && i < 9)) ? 16'h8000 : 16'h7FFF;
      d.push_back(c);
      for (int i = 0; i < 12; i++) c[i] = (i % 3 == 0) ? ((i % 2) ? 16'h7FFF : 16'h8000) : 16'h0;
      d.push_back(c);
      c = '0; c[0] = 16'h0200; c[3] = 16'hFE00; c[9] = 16'h0001; c[10] = 16'h0001;
      d.push_back(c);
      c = '0; c[0] = 16'h0300; c[4] = 16'h0300; c[6] = 16'h0001; c[11] = 16'h0001;
      d.push_back(c);
      for (int i = 0; i < 12; i++) c[i] = 16'hFFFF;
      d.push_back(c);
      c = '0; c[0] = 16'h8000; c[1] = 16'h8000; c[2] = 16'h8000; c[9] = 16'h0001;
      d.push_back(c);
      c = '0; c[3] = 16'h0001; c[9] = 16'hFFFF; c[10] = 16'h0001;
      d.push_back(c);
      foreach (d[i]) offer(d[i]);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         offer(random_pair());
         if (n == 500) drain_results();
      end
      drain_results();
      repeat (80) @(posedge clock);

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
